// File: src/mesh_vertex_gradient_top_assert.svh
// Concurrent assertion helpers, compiled out when ASSERT_OFF is set.
`ifndef MESH_VERTEX_GRADIENT_TOP_ASSERT_SVH
`define MESH_VERTEX_GRADIENT_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define MVG_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MVG_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define MVG_ASSERT(label, clk, rst_n, prop, msg)
`define MVG_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif

`endif

// File: src/mvg_pkg.sv
package mvg_pkg;

    localparam int COORD_BITS  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int NORM_BITS   = 16;
    localparam int NORM_FRAC   = 14;
    localparam int ACC_BITS    = 64;
    localparam int AREA_BITS   = 48;

    localparam int REL_W       = COORD_BITS + 1;
    localparam int DOT_SUM_W   = REL_W + NORM_BITS + 2;
    localparam int DOT_W       = DOT_SUM_W - NORM_FRAC;
    localparam int OFF_W       = DOT_W + NORM_BITS - NORM_FRAC + 1;
    localparam int MA_W        = DOT_W;
    localparam int MB_W        = COORD_BITS;
    localparam int PROD_W      = MA_W + MB_W;
    localparam int DVD_W       = ACC_BITS + FRAC_BITS;
    localparam int QUO_W       = COORD_BITS + 1;
    localparam int SQRT_STEPS  = ACC_BITS / 2;
    localparam int CNT_W       = $clog2(DVD_W);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        KIND_HEADER   = 1'b0,
        KIND_NEIGHBOR = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind                         kind;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
        logic signed [NORM_BITS-1:0]  norm_x;
        logic signed [NORM_BITS-1:0]  norm_y;
        logic signed [NORM_BITS-1:0]  norm_z;
        logic signed [COORD_BITS-1:0] field_value;
        logic        [COORD_BITS-1:0] point_area;
        logic                          last;
    } t_item;

endpackage

// File: src/mvg_if.sv
interface mvg_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  cmd;
    logic signed [mvg_pkg::COORD_BITS-1:0] pos_x;
    logic signed [mvg_pkg::COORD_BITS-1:0] pos_y;
    logic signed [mvg_pkg::COORD_BITS-1:0] pos_z;
    logic signed [mvg_pkg::NORM_BITS-1:0]  norm_x;
    logic signed [mvg_pkg::NORM_BITS-1:0]  norm_y;
    logic signed [mvg_pkg::NORM_BITS-1:0]  norm_z;
    logic signed [mvg_pkg::COORD_BITS-1:0] field_value;
    logic        [mvg_pkg::COORD_BITS-1:0] point_area;
    logic                                  last;

    modport source (output valid, cmd, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                    field_value, point_area, last, input ready);
    modport sink   (input valid, cmd, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                    field_value, point_area, last, output ready);
endinterface

interface mvg_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [mvg_pkg::COORD_BITS-1:0] grad_x;
    logic signed [mvg_pkg::COORD_BITS-1:0] grad_y;
    logic signed [mvg_pkg::COORD_BITS-1:0] grad_z;
    logic        [mvg_pkg::COORD_BITS-1:0] magnitude;
    logic                                  zero_area;

    modport source (output valid, grad_x, grad_y, grad_z, magnitude, zero_area,
                    input ready);
    modport sink   (input valid, grad_x, grad_y, grad_z, magnitude, zero_area,
                    output ready);
endinterface

// File: src/mesh_vertex_gradient_top.sv
// Vertex gradient engine on a triangle mesh, Q16.16 fixed point.
// Input channel i_in: a header item (cmd 0) loads the center position,
// unit normal and field value and clears the sums; each neighbor item
// (cmd 1) adds one area-weighted tangent-plane contribution. An item with
// last set closes the vertex and yields one result on o_out.
// Items enter a two-entry queue, so the source keeps streaming while the
// back end computes. A neighbor makes twelve passes through one shared
// 37x32 multiplier, each a multiply state and a use state. Closing a
// vertex runs a bit-serial divider for each of the 3 components, three
// squares on the multiplier and a 32-step integer square root; a zero
// total area skips all three and gives a zero result.
// The result sits in an output register; while o_out is stalled the back
// end holds at the result stage and the queue fills, then i_in.ready drops.
// Synchronous active-low reset empties the queue, drops the output and
// clears the center and all sums to zero.
module mesh_vertex_gradient_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mvg_in_if.sink    i_in,
    mvg_out_if.source o_out
);
    import mvg_pkg::*;

    t_item w_item;
    logic  w_item_valid;
    logic  w_item_ready;

    mvg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_item       (w_item),
        .o_item_valid (w_item_valid),
        .i_item_ready (w_item_ready)
    );

    mvg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_item),
        .i_item_valid (w_item_valid),
        .o_item_ready (w_item_ready),
        .o_out        (o_out)
    );

endmodule

// File: src/mvg_front.sv
`include "mesh_vertex_gradient_top_assert.svh"

module mvg_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mvg_in_if.sink         i_in,
    output mvg_pkg::t_item o_item,
    output logic           o_item_valid,
    input  logic           i_item_ready
);
    import mvg_pkg::*;

    t_item             r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_count;
    t_item             w_item;
    logic              w_push;
    logic              w_pop;

    always_comb begin
        w_item.kind        = t_kind'(i_in.cmd);
        w_item.pos_x       = i_in.pos_x;
        w_item.pos_y       = i_in.pos_y;
        w_item.pos_z       = i_in.pos_z;
        w_item.norm_x      = i_in.norm_x;
        w_item.norm_y      = i_in.norm_y;
        w_item.norm_z      = i_in.norm_z;
        w_item.field_value = i_in.field_value;
        w_item.point_area  = i_in.point_area;
        w_item.last        = i_in.last;
    end

    assign i_in.ready   = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign w_push       = i_in.valid & i_in.ready;
    assign o_item_valid = (r_count != '0);
    assign o_item       = r_q[r_rp];
    assign w_pop        = o_item_valid & i_item_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `MVG_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
    `MVG_ASSERT(a_full_stalls, i_clk, i_rst_n, (r_count == QCNT_W'(QUEUE_DEPTH)) |-> !i_in.ready, "accept while full")
    `MVG_ASSERT_NEXT(a_push_counts, i_clk, i_rst_n, (w_push && !w_pop), (r_count == $past(r_count) + 1'b1), "lost item")

endmodule

// File: src/mvg_back.sv
`include "mesh_vertex_gradient_top_assert.svh"

module mvg_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mvg_pkg::t_item i_item,
    input  logic           i_item_valid,
    output logic           o_item_ready,
    mvg_out_if.source      o_out
);
    import mvg_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_NB_MUL = 9'b000000010,
        S_NB_USE = 9'b000000100,
        S_FIN    = 9'b000001000,
        S_DIV    = 9'b000010000,
        S_SQ_MUL = 9'b000100000,
        S_SQ_USE = 9'b001000000,
        S_SQRT   = 9'b010000000,
        S_OUT    = 9'b100000000
    } t_state;

    typedef enum logic [1:0] {
        PH_DOT  = 2'd0,
        PH_PROJ = 2'd1,
        PH_AREA = 2'd2,
        PH_DIFF = 2'd3
    } t_phase;

    localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic signed [PROD_W-1:0]     CMAX_P = PROD_W'(CMAX);
    localparam logic signed [PROD_W-1:0]     CMIN_P = PROD_W'(CMIN);
    localparam logic [ACC_BITS-1:0]          BIT_INIT = {2'b01, {(ACC_BITS-2){1'b0}}};

    function automatic logic signed [COORD_BITS-1:0] sat_c(input logic signed [PROD_W-1:0] v);
        logic signed [COORD_BITS-1:0] res;
        if (v > CMAX_P) begin
            res = CMAX;
        end else if (v < CMIN_P) begin
            res = CMIN;
        end else begin
            res = v[COORD_BITS-1:0];
        end
        return res;
    endfunction

    function automatic logic signed [ACC_BITS-1:0] sat_acc(input logic signed [ACC_BITS:0] v);
        logic signed [ACC_BITS-1:0] res;
        if (v[ACC_BITS] != v[ACC_BITS-1]) begin
            res = v[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, {(ACC_BITS-1){1'b1}}};
        end else begin
            res = v[ACC_BITS-1:0];
        end
        return res;
    endfunction

    t_state                       r_state;
    t_phase                       r_phase;
    logic [1:0]                   r_k;
    logic [CNT_W-1:0]             r_cnt;

    logic signed [COORD_BITS-1:0] r_cpos  [3];
    logic signed [NORM_BITS-1:0]  r_cnorm [3];
    logic signed [COORD_BITS-1:0] r_cval;
    logic signed [ACC_BITS-1:0]   r_ws    [3];
    logic [AREA_BITS-1:0]         r_area_tot;

    logic signed [REL_W-1:0]      r_rel   [3];
    logic signed [COORD_BITS-1:0] r_diff;
    logic [COORD_BITS-1:0]        r_area;
    logic                         r_last;
    logic signed [DOT_SUM_W-1:0]  r_dotacc;
    logic signed [DOT_W-1:0]      r_dot;
    logic signed [COORD_BITS-1:0] r_off   [3];
    logic signed [COORD_BITS-1:0] r_t     [3];
    logic signed [PROD_W-1:0]     r_prod;

    logic [DVD_W-1:0]             r_dvd;
    logic [AREA_BITS-1:0]         r_rem;
    logic [QUO_W-1:0]             r_quo;
    logic                         r_ovf;
    logic signed [COORD_BITS-1:0] r_g     [3];
    logic [ACC_BITS-1:0]          r_sq;
    logic [ACC_BITS-1:0]          r_sn;
    logic [ACC_BITS-1:0]          r_sr;
    logic [ACC_BITS-1:0]          r_sbit;
    logic                         r_zero;

    logic                         r_ov;
    logic signed [COORD_BITS-1:0] r_og    [3];
    logic [COORD_BITS-1:0]        r_omag;
    logic                         r_oza;

    logic signed [MA_W-1:0]       w_op_a;
    logic signed [MB_W-1:0]       w_op_b;
    logic signed [PROD_W-1:0]     w_prod;
    logic signed [PROD_W-1:0]     w_sh14;
    logic signed [PROD_W-1:0]     w_sh16;
    logic signed [DOT_SUM_W-1:0]  w_dot_sum;
    logic signed [OFF_W-1:0]      w_offw;
    logic signed [ACC_BITS:0]     w_wsum;
    logic signed [REL_W-1:0]      w_diffw;
    logic [AREA_BITS:0]           w_at_sum;
    logic                         w_pop;

    logic [AREA_BITS:0]           w_rsh;
    logic                         w_ge;
    logic [AREA_BITS:0]           w_rsub;
    logic [QUO_W-1:0]             w_quo;
    logic                         w_ovf;
    logic                         w_big;
    logic signed [COORD_BITS-1:0] w_gval;
    logic [ACC_BITS-1:0]          w_mag_next;
    logic [1:0]                   w_k_next;

    logic [ACC_BITS-1:0]          w_stry;
    logic                         w_sge;
    logic [ACC_BITS-1:0]          w_sq_sum;

    assign o_item_ready = (r_state == S_IDLE);
    assign w_pop        = i_item_valid & o_item_ready;

    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        if (r_state == S_SQ_MUL) begin
            w_op_a = MA_W'(r_g[r_k]);
            w_op_b = MB_W'(r_g[r_k]);
        end else begin
            case (r_phase)
                PH_DOT: begin
                    w_op_a = MA_W'(r_rel[r_k]);
                    w_op_b = MB_W'(r_cnorm[r_k]);
                end
                PH_PROJ: begin
                    w_op_a = r_dot;
                    w_op_b = MB_W'(r_cnorm[r_k]);
                end
                PH_AREA: begin
                    w_op_a = MA_W'($signed({1'b0, r_area}));
                    w_op_b = r_off[r_k];
                end
                default: begin
                    w_op_a = MA_W'(r_t[r_k]);
                    w_op_b = r_diff;
                end
            endcase
        end
    end

    assign w_prod    = PROD_W'(w_op_a) * PROD_W'(w_op_b);
    assign w_sh14    = r_prod >>> NORM_FRAC;
    assign w_sh16    = r_prod >>> FRAC_BITS;
    assign w_dot_sum = r_dotacc + DOT_SUM_W'(r_prod);
    assign w_offw    = OFF_W'(r_rel[r_k]) - OFF_W'(w_sh14);
    assign w_wsum    = (ACC_BITS+1)'(r_ws[r_k]) + (ACC_BITS+1)'(w_sh16);
    assign w_diffw   = REL_W'(i_item.field_value) - REL_W'(r_cval);
    assign w_at_sum  = (AREA_BITS+1)'(r_area_tot) + (AREA_BITS+1)'(i_item.point_area);
    assign w_k_next  = r_k + 1'b1;

    assign w_rsh  = {r_rem, r_dvd[DVD_W-1]};
    assign w_ge   = (w_rsh >= {1'b0, r_area_tot});
    assign w_rsub = w_rsh - {1'b0, r_area_tot};
    assign w_quo  = {r_quo[QUO_W-2:0], w_ge};
    assign w_ovf  = r_ovf | r_quo[QUO_W-1];
    assign w_big  = w_ovf | w_quo[QUO_W-1];

    always_comb begin
        if (r_ws[r_k][ACC_BITS-1]) begin
            if (w_big || (w_quo[COORD_BITS-1] && (|w_quo[COORD_BITS-2:0]))) begin
                w_gval = CMIN;
            end else begin
                w_gval = -$signed(w_quo[COORD_BITS-1:0]);
            end
        end else begin
            if (w_big || w_quo[COORD_BITS-1]) begin
                w_gval = CMAX;
            end else begin
                w_gval = $signed(w_quo[COORD_BITS-1:0]);
            end
        end
    end

    always_comb begin
        if (r_ws[w_k_next][ACC_BITS-1]) begin
            w_mag_next = ACC_BITS'(-r_ws[w_k_next]);
        end else begin
            w_mag_next = r_ws[w_k_next];
        end
    end

    assign w_stry   = r_sr + r_sbit;
    assign w_sge    = (r_sn >= w_stry);
    assign w_sq_sum = r_sq + ACC_BITS'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase    <= PH_DOT;
            r_k        <= '0;
            r_cnt      <= '0;
            r_ov       <= 1'b0;
            r_cval     <= '0;
            r_area_tot <= '0;
            for (int i = 0; i < 3; i++) begin
                r_cpos[i]  <= '0;
                r_cnorm[i] <= '0;
                r_ws[i]    <= '0;
            end
        end else begin
            if (r_ov && o_out.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_pop) begin
                        r_last <= i_item.last;
                        if (i_item.kind == KIND_HEADER) begin
                            r_cpos[0]  <= i_item.pos_x;
                            r_cpos[1]  <= i_item.pos_y;
                            r_cpos[2]  <= i_item.pos_z;
                            r_cnorm[0] <= i_item.norm_x;
                            r_cnorm[1] <= i_item.norm_y;
                            r_cnorm[2] <= i_item.norm_z;
                            r_cval     <= i_item.field_value;
                            r_area_tot <= '0;
                            for (int i = 0; i < 3; i++) begin
                                r_ws[i] <= '0;
                            end
                            if (i_item.last) begin
                                r_state <= S_FIN;
                            end
                        end else begin
                            r_rel[0]   <= REL_W'(i_item.pos_x) - REL_W'(r_cpos[0]);
                            r_rel[1]   <= REL_W'(i_item.pos_y) - REL_W'(r_cpos[1]);
                            r_rel[2]   <= REL_W'(i_item.pos_z) - REL_W'(r_cpos[2]);
                            r_diff     <= sat_c(PROD_W'(w_diffw));
                            r_area     <= i_item.point_area;
                            r_area_tot <= w_at_sum[AREA_BITS] ? '1 : w_at_sum[AREA_BITS-1:0];
                            r_dotacc   <= '0;
                            r_phase    <= PH_DOT;
                            r_k        <= '0;
                            r_state    <= S_NB_MUL;
                        end
                    end
                end
                S_NB_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= S_NB_USE;
                end
                S_NB_USE: begin
                    case (r_phase)
                        PH_DOT: begin
                            r_dotacc <= w_dot_sum;
                            r_dot    <= DOT_W'(w_dot_sum >>> NORM_FRAC);
                        end
                        PH_PROJ: r_off[r_k] <= sat_c(PROD_W'(w_offw));
                        PH_AREA: r_t[r_k]   <= sat_c(w_sh16);
                        default: r_ws[r_k]  <= sat_acc(w_wsum);
                    endcase
                    if (r_k == 2'd2) begin
                        r_k <= '0;
                        if (r_phase == PH_DIFF) begin
                            r_state <= r_last ? S_FIN : S_IDLE;
                        end else begin
                            r_phase <= t_phase'(r_phase + 1'b1);
                            r_state <= S_NB_MUL;
                        end
                    end else begin
                        r_k     <= w_k_next;
                        r_state <= S_NB_MUL;
                    end
                end
                S_FIN: begin
                    r_k   <= '0;
                    r_cnt <= '0;
                    if (r_area_tot == '0) begin
                        r_zero <= 1'b1;
                        r_sr   <= '0;
                        for (int i = 0; i < 3; i++) begin
                            r_g[i] <= '0;
                        end
                        r_state <= S_OUT;
                    end else begin
                        r_zero  <= 1'b0;
                        r_dvd   <= {(r_ws[0][ACC_BITS-1] ? ACC_BITS'(-r_ws[0]) : r_ws[0]),
                                    FRAC_BITS'(0)};
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= w_ge ? w_rsub[AREA_BITS-1:0] : w_rsh[AREA_BITS-1:0];
                    r_quo <= w_quo;
                    r_ovf <= w_ovf;
                    r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DVD_W - 1)) begin
                        r_g[r_k] <= w_gval;
                        r_cnt    <= '0;
                        r_rem    <= '0;
                        r_quo    <= '0;
                        r_ovf    <= 1'b0;
                        if (r_k == 2'd2) begin
                            r_k     <= '0;
                            r_sq    <= '0;
                            r_state <= S_SQ_MUL;
                        end else begin
                            r_k   <= w_k_next;
                            r_dvd <= {w_mag_next, FRAC_BITS'(0)};
                        end
                    end
                end
                S_SQ_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= S_SQ_USE;
                end
                S_SQ_USE: begin
                    r_sq <= w_sq_sum;
                    if (r_k == 2'd2) begin
                        r_k     <= '0;
                        r_sn    <= w_sq_sum;
                        r_sr    <= '0;
                        r_sbit  <= BIT_INIT;
                        r_cnt   <= '0;
                        r_state <= S_SQRT;
                    end else begin
                        r_k     <= w_k_next;
                        r_state <= S_SQ_MUL;
                    end
                end
                S_SQRT: begin
                    if (w_sge) begin
                        r_sn <= r_sn - w_stry;
                        r_sr <= (r_sr >> 1) + r_sbit;
                    end else begin
                        r_sr <= r_sr >> 1;
                    end
                    r_sbit <= r_sbit >> 2;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ov || o_out.ready) begin
                        r_ov       <= 1'b1;
                        r_og[0]    <= r_g[0];
                        r_og[1]    <= r_g[1];
                        r_og[2]    <= r_g[2];
                        r_omag     <= (|r_sr[ACC_BITS-1:COORD_BITS]) ? '1 : r_sr[COORD_BITS-1:0];
                        r_oza      <= r_zero;
                        r_area_tot <= '0;
                        for (int i = 0; i < 3; i++) begin
                            r_ws[i] <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.grad_x    = r_og[0];
    assign o_out.grad_y    = r_og[1];
    assign o_out.grad_z    = r_og[2];
    assign o_out.magnitude = r_omag;
    assign o_out.zero_area = r_oza;

    `MVG_ASSERT(a_zero_result, i_clk, i_rst_n, (r_ov && r_oza) |-> ((r_og[0] == '0) && (r_og[1] == '0) && (r_og[2] == '0) && (r_omag == '0)), "zero area result not zero")
    `MVG_ASSERT(a_rem_bound, i_clk, i_rst_n, (r_state == S_DIV) |-> (r_rem < r_area_tot), "remainder not below divisor")
    `MVG_ASSERT_NEXT(a_nb_start, i_clk, i_rst_n, (w_pop && (i_item.kind == KIND_NEIGHBOR)), (r_state == S_NB_MUL), "neighbor did not start")

endmodule

// File: test/testbench.sv
module testbench;
    import mvg_pkg::*;

    localparam int  LIMIT    = 3000000;
    localparam int  MAX_WAIT = 12;
    localparam longint AREA_CAP = (64'sd1 <<< 48) - 1;

    typedef struct {
        logic [COORD_BITS-1:0] grad_x;
        logic [COORD_BITS-1:0] grad_y;
        logic [COORD_BITS-1:0] grad_z;
        logic [COORD_BITS-1:0] magnitude;
        logic                  zero_area;
    } t_grad;

    class gradient_scoreboard;
        longint center_pos[3];
        longint center_nrm[3];
        longint center_val;
        longint wsum[3];
        longint area_sum;
        t_grad  expected_q[$];
        int     errors;

        function new();
            foreach (center_pos[k]) begin
                center_pos[k] = 0;
                center_nrm[k] = 0;
                wsum[k] = 0;
            end
            center_val = 0;
            area_sum = 0;
            errors = 0;
        endfunction

        function longint mul_sat(longint a, longint b);
            logic signed [127:0] p;
            p = 128'(a) * 128'(b);
            if (p > 128'sh7FFFFFFFFFFFFFFF) return 64'sh7FFFFFFFFFFFFFFF;
            if (p < -128'sh8000000000000000) return 64'sh8000000000000000;
            return longint'(p);
        endfunction

        function longint add_sat(longint a, longint b);
            logic signed [64:0] s;
            s = 65'(a) + 65'(b);
            if (s > 65'sh07FFFFFFFFFFFFFFF) return 64'sh7FFFFFFFFFFFFFFF;
            if (s < -65'sh08000000000000000) return 64'sh8000000000000000;
            return longint'(s);
        endfunction

        function longint clamp_coord(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint quotient(longint s, longint unsigned a);
            longint unsigned m, q, r, lim, cap;
            bit sat;
            m = (s < 0) ? (64'd0 - 64'(s)) : 64'(s);
            q = m / a;
            r = m % a;
            lim = 64'd1 << COORD_BITS;
            cap = 64'd1 << (COORD_BITS - 1);
            sat = 0;
            for (int i = 0; i < FRAC_BITS; i++) begin
                if (q >= lim) begin
                    sat = 1;
                    break;
                end
                r = r << 1;
                q = q << 1;
                if (r >= a) begin
                    r = r - a;
                    q = q | 1;
                end
            end
            if (s < 0) begin
                if (sat || q > cap) q = cap;
                return -longint'(q);
            end
            if (sat || q > cap - 1) q = cap - 1;
            return longint'(q);
        endfunction

        function longint unsigned root(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function void note_input(t_item it);
            longint pos[3], nrm[3], rel[3];
            longint dot, diff, off, t, area;
            longint unsigned sq, mg, s2;
            t_grad g;
            pos[0] = it.pos_x; pos[1] = it.pos_y; pos[2] = it.pos_z;
            nrm[0] = it.norm_x; nrm[1] = it.norm_y; nrm[2] = it.norm_z;
            if (it.kind == KIND_HEADER) begin
                foreach (pos[k]) begin
                    center_pos[k] = pos[k];
                    center_nrm[k] = nrm[k];
                    wsum[k] = 0;
                end
                center_val = it.field_value;
                area_sum = 0;
            end else begin
                area = longint'({32'd0, it.point_area});
                dot = 0;
                foreach (rel[k]) begin
                    rel[k] = pos[k] - center_pos[k];
                    dot = add_sat(dot, mul_sat(rel[k], center_nrm[k]));
                end
                dot = dot >>> NORM_FRAC;
                diff = clamp_coord(longint'(it.field_value) - center_val);
                foreach (rel[k]) begin
                    off = clamp_coord(rel[k] - (mul_sat(dot, center_nrm[k]) >>> NORM_FRAC));
                    t = clamp_coord(mul_sat(area, off) >>> FRAC_BITS);
                    wsum[k] = add_sat(wsum[k], mul_sat(t, diff) >>> FRAC_BITS);
                end
                area_sum = area_sum + area;
                if (area_sum > AREA_CAP) area_sum = AREA_CAP;
            end
            if (!it.last) return;
            if (area_sum == 0) begin
                g = '{0, 0, 0, 0, 1'b1};
            end else begin
                longint q[3];
                sq = 0;
                foreach (q[k]) begin
                    q[k] = quotient(wsum[k], longint'(area_sum));
                    mg = (q[k] < 0) ? 64'd0 - 64'(q[k]) : 64'(q[k]);
                    s2 = (mg > 64'hFFFFFFFF) ? '1 : mg * mg;
                    sq = (sq > ~64'd0 - s2) ? '1 : sq + s2;
                end
                mg = root(sq);
                if (mg > 64'hFFFFFFFF) mg = 64'hFFFFFFFF;
                g = '{q[0][31:0], q[1][31:0], q[2][31:0], mg[31:0], 1'b0};
            end
            expected_q.push_back(g);
            foreach (wsum[k]) wsum[k] = 0;
            area_sum = 0;
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %h expected %h", what, got, want);
            errors++;
        endtask

        task check(t_grad r);
            t_grad e;
            if (expected_q.size() == 0) begin
                report("unexpected result", r.grad_x, 0);
                return;
            end
            e = expected_q.pop_front();
            if (r.grad_x !== e.grad_x) report("grad_x", r.grad_x, e.grad_x);
            if (r.grad_y !== e.grad_y) report("grad_y", r.grad_y, e.grad_y);
            if (r.grad_z !== e.grad_z) report("grad_z", r.grad_z, e.grad_z);
            if (r.magnitude !== e.magnitude) report("magnitude", r.magnitude, e.magnitude);
            if (r.zero_area !== e.zero_area) report("zero_area", r.zero_area, e.zero_area);
        endtask
    endclass

    logic clk = 0;
    logic rst_n;
    int   cycles = 0;
    bit   stim_done = 0;
    gradient_scoreboard sb = new();

    mvg_in_if  in_ch();
    mvg_out_if out_ch();

    mesh_vertex_gradient_top dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in(in_ch),
        .o_out(out_ch)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
            2: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
            3: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            4: return '0;
            default: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
        endcase
    endfunction

    function automatic logic [15:0] rand_norm();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
            1: return '0;
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic logic [31:0] rand_area();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return '0;
            default: return $urandom_range(0, 1 << 18);
        endcase
    endfunction

    function automatic t_item make_item(t_kind kind, logic last);
        t_item it;
        it.kind = kind;
        it.pos_x = rand_word();
        it.pos_y = rand_word();
        it.pos_z = rand_word();
        it.norm_x = rand_norm();
        it.norm_y = rand_norm();
        it.norm_z = rand_norm();
        it.field_value = rand_word();
        it.point_area = rand_area();
        it.last = last;
        return it;
    endfunction

    task automatic send(t_item it);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd <= it.kind;
        in_ch.pos_x <= it.pos_x;
        in_ch.pos_y <= it.pos_y;
        in_ch.pos_z <= it.pos_z;
        in_ch.norm_x <= it.norm_x;
        in_ch.norm_y <= it.norm_y;
        in_ch.norm_z <= it.norm_z;
        in_ch.field_value <= it.field_value;
        in_ch.point_area <= it.point_area;
        in_ch.last <= it.last;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_input(it);
    endtask

    task automatic send_vertex(int nn);
        send(make_item(KIND_HEADER, nn == 0));
        for (int i = 0; i < nn; i++) send(make_item(KIND_NEIGHBOR, i == nn - 1));
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.expected_q.size() != 0);
    endtask

    initial begin
        t_item it;
        int sent;
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.cmd <= 1'b0;
        in_ch.pos_x <= '0;
        in_ch.pos_y <= '0;
        in_ch.pos_z <= '0;
        in_ch.norm_x <= '0;
        in_ch.norm_y <= '0;
        in_ch.norm_z <= '0;
        in_ch.field_value <= '0;
        in_ch.point_area <= '0;
        in_ch.last <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // neighbor against the reset center
        it = make_item(KIND_NEIGHBOR, 1'b1);
        it.point_area = 32'h00010000;
        send(it);
        // header closing the vertex alone
        send(make_item(KIND_HEADER, 1'b1));
        // extremes
        it = make_item(KIND_HEADER, 1'b0);
        it.pos_x = 32'h80000000; it.pos_y = 32'h7FFFFFFF; it.pos_z = 0;
        it.norm_x = 16'sd16384; it.norm_y = -16'sd16384; it.norm_z = 16'sd16384;
        it.field_value = 32'h80000000;
        send(it);
        it = make_item(KIND_NEIGHBOR, 1'b0);
        it.pos_x = 32'h7FFFFFFF; it.pos_y = 32'h80000000; it.pos_z = 32'hFFFFFFFF;
        it.field_value = 32'h7FFFFFFF; it.point_area = 32'hFFFFFFFF;
        send(it);
        it.pos_x = 32'h80000000; it.point_area = 32'hFFFFFFFF; it.last = 1'b1;
        send(it);
        // zero total area over several neighbors
        send(make_item(KIND_HEADER, 1'b0));
        for (int i = 0; i < 3; i++) begin
            it = make_item(KIND_NEIGHBOR, i == 2);
            it.point_area = 0;
            send(it);
        end
        // unit normal along z, small x offsets
        it = make_item(KIND_HEADER, 1'b0);
        it.norm_x = 0; it.norm_y = 0; it.norm_z = 16'sd16384;
        it.pos_x = 0; it.pos_y = 0; it.pos_z = 0; it.field_value = 0;
        send(it);
        for (int i = 0; i < 4; i++) begin
            it = make_item(KIND_NEIGHBOR, i == 3);
            it.pos_x = 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
            it.point_area = 32'h00008000;
            send(it);
        end
        drain();

        sent = 14;
        while (sent < 1050) begin
            int nn;
            if ($urandom_range(0, 9) == 0) begin
                send(make_item(t_kind'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
                sent++;
            end else begin
                nn = $urandom_range(0, 5) == 0 ? $urandom_range(0, 12) : $urandom_range(1, 4);
                send_vertex(nn);
                sent += nn + 1;
            end
            if ($urandom_range(0, 40) == 0) drain();
        end
        drain();
        stim_done = 1;
    end

    initial begin
        t_grad r;
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (1) begin
            stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!(out_ch.valid && rst_n));
            r = '{out_ch.grad_x, out_ch.grad_y, out_ch.grad_z,
                  out_ch.magnitude, out_ch.zero_area};
            sb.check(r);
        end
    end

    initial begin
        wait (stim_done);
        repeat (400) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
